/* sv/ufef_pkg.sv */
// Shared types and constants of the union-find edge filter.
// Holds opcodes, microcode condition codes and the control word passed
// from the sequencer to the datapath. Depends on nothing.
package ufef_pkg;

	localparam int unsigned NODE_W  = 10;
	localparam int unsigned COUNT_W = 10;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned STEP_W  = 4;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [NODE_W-1:0]  NODE_COUNT_RST = 10'd1023;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LINK  = 2'd1,
		OP_OFFER = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOFIRE,
		C_OPCLR,
		C_OPNONE,
		C_RDNE,
		C_CUREQ,
		C_SELB,
		C_CLRDONE,
		C_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_ROOT,
		RD_CUR
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CUR,
		WR_PA,
		WR_CLR
	} wr_sel_t;

	typedef struct packed {
		logic    take;
		logic    ld_quot;
		logic    ld_idx;
		logic    ld_find;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    ld_root_rd;
		logic    ld_cur_rd;
		logic    ld_pa;
		logic    ld_union;
		logic    clr_init;
		logic    clr_inc;
		logic    ld_out;
	} ctl_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] tgt;
		ctl_t              ctl;
	} ucode_t;

	typedef struct packed {
		logic fire;
		logic op_clr;
		logic op_none;
		logic rd_ne_root;
		logic cur_eq_root;
		logic sel_b;
		logic clr_done;
		logic out_busy;
	} status_t;

endpackage

/* sv/ufef_ifs.sv */
// Channel interfaces of the union-find edge filter: edge items, results and
// the node count write channel. Depends on ufef_pkg for field widths.
interface ufef_in_if import ufef_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	modport source (output valid, output opcode, output node_a, output node_b, input ready);
	modport sink (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

interface ufef_out_if import ufef_pkg::*;;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [COUNT_W-1:0] accepted_total;
	modport source (output valid, output accepted, output accepted_total, input ready);
	modport sink (input valid, input accepted, input accepted_total, output ready);
endinterface

interface ufef_cfg_if import ufef_pkg::*;;
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_count;
	modport source (output valid, output node_count, input ready);
	modport sink (input valid, input node_count, output ready);
endinterface

/* sv/ufef_sequencer.sv */
// Microcode sequencer: step counter, program table and jump logic.
// Drives the datapath with one control word per step. Depends on ufef_pkg.
module ufef_sequencer import ufef_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctl_t    ctl
);

	localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] S_DISP  = 4'd1;
	localparam logic [STEP_W-1:0] S_CHKOP = 4'd2;
	localparam logic [STEP_W-1:0] S_FINIT = 4'd3;
	localparam logic [STEP_W-1:0] S_WRD   = 4'd4;
	localparam logic [STEP_W-1:0] S_WCHK  = 4'd5;
	localparam logic [STEP_W-1:0] S_CCHK  = 4'd6;
	localparam logic [STEP_W-1:0] S_CWR   = 4'd7;
	localparam logic [STEP_W-1:0] S_FEND  = 4'd8;
	localparam logic [STEP_W-1:0] S_NEXTB = 4'd9;
	localparam logic [STEP_W-1:0] S_UNION = 4'd10;
	localparam logic [STEP_W-1:0] S_FIN   = 4'd11;
	localparam logic [STEP_W-1:0] S_EMIT  = 4'd12;
	localparam logic [STEP_W-1:0] S_CL0   = 4'd13;
	localparam logic [STEP_W-1:0] S_CL1   = 4'd14;
	localparam logic [STEP_W-1:0] S_CL2   = 4'd15;

	logic [STEP_W-1:0] step_q;
	ucode_t            uw;
	logic              jump;

	function automatic ucode_t rom(input logic [STEP_W-1:0] s);
		ucode_t w;
		w = '0;
		w.cond = C_NEXT;
		w.tgt = S_IDLE;
		w.ctl.rd_sel = RD_NONE;
		w.ctl.wr_sel = WR_NONE;
		unique case (s)
			S_IDLE: begin
				w.ctl.take = 1'b1;
				w.cond = C_NOFIRE;
				w.tgt = S_IDLE;
			end
			S_DISP: begin
				w.ctl.ld_quot = 1'b1;
				w.cond = C_OPCLR;
				w.tgt = S_CL0;
			end
			S_CHKOP: begin
				w.ctl.ld_idx = 1'b1;
				w.cond = C_OPNONE;
				w.tgt = S_FIN;
			end
			S_FINIT: begin
				w.ctl.ld_find = 1'b1;
			end
			S_WRD: begin
				w.ctl.rd_sel = RD_ROOT;
			end
			S_WCHK: begin
				w.ctl.ld_root_rd = 1'b1;
				w.cond = C_RDNE;
				w.tgt = S_WRD;
			end
			S_CCHK: begin
				w.ctl.rd_sel = RD_CUR;
				w.cond = C_CUREQ;
				w.tgt = S_FEND;
			end
			S_CWR: begin
				w.ctl.wr_sel = WR_CUR;
				w.ctl.ld_cur_rd = 1'b1;
				w.cond = C_ALWAYS;
				w.tgt = S_CCHK;
			end
			S_FEND: begin
				w.cond = C_SELB;
				w.tgt = S_UNION;
			end
			S_NEXTB: begin
				w.ctl.ld_pa = 1'b1;
				w.cond = C_ALWAYS;
				w.tgt = S_FINIT;
			end
			S_UNION: begin
				w.ctl.wr_sel = WR_PA;
				w.ctl.ld_union = 1'b1;
			end
			S_FIN: begin
				w.cond = C_BUSY;
				w.tgt = S_FIN;
			end
			S_EMIT: begin
				w.ctl.ld_out = 1'b1;
				w.cond = C_ALWAYS;
				w.tgt = S_IDLE;
			end
			S_CL0: begin
				w.ctl.clr_init = 1'b1;
			end
			S_CL1: begin
				w.cond = C_CLRDONE;
				w.tgt = S_FIN;
			end
			S_CL2: begin
				w.ctl.wr_sel = WR_CLR;
				w.ctl.clr_inc = 1'b1;
				w.cond = C_ALWAYS;
				w.tgt = S_CL1;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.tgt = S_IDLE;
			end
		endcase
		return w;
	endfunction

	assign uw = rom(step_q);
	assign ctl = uw.ctl;

	always_comb begin
		unique case (uw.cond)
			C_NEXT:    jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NOFIRE:  jump = !status.fire;
			C_OPCLR:   jump = status.op_clr;
			C_OPNONE:  jump = status.op_none;
			C_RDNE:    jump = status.rd_ne_root;
			C_CUREQ:   jump = status.cur_eq_root;
			C_SELB:    jump = status.sel_b;
			C_CLRDONE: jump = status.clr_done;
			C_BUSY:    jump = status.out_busy;
			default:   jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= jump ? uw.tgt : step_q + 1'b1;
		end
	end

endmodule

/* sv/ufef_datapath.sv */
// Datapath of the union-find edge filter: parent table memory, node index
// reduction, walk registers, accept counter and the result register.
// Controlled by ufef_sequencer; depends on ufef_pkg.
module ufef_datapath import ufef_pkg::*; #(
	parameter int unsigned MAX_NODES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	output status_t            status,
	input  logic               in_valid,
	input  logic [OP_W-1:0]    in_opcode,
	input  logic [NODE_W-1:0]  in_node_a,
	input  logic [NODE_W-1:0]  in_node_b,
	input  logic               cfg_valid,
	input  logic [NODE_W-1:0]  cfg_node_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_accepted,
	output logic [COUNT_W-1:0] out_total
);

	localparam int unsigned IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned SHIFT   = 2 * NODE_W;
	localparam int unsigned RECIP   = ((2 ** SHIFT) + MAX_NODES - 1) / MAX_NODES;
	localparam int unsigned PROD_W  = SHIFT + NODE_W + 1;
	localparam int unsigned REM_W   = NODE_W + IDX_W + 1;
	localparam int unsigned CLR_W   = NODE_W + 1;

	logic [IDX_W-1:0] mem [MAX_NODES];

	logic [OP_W-1:0]    op_q;
	logic [NODE_W-1:0]  a_q, b_q;
	logic [NODE_W-1:0]  qa_q, qb_q;
	logic [IDX_W-1:0]   a_idx_q, b_idx_q;
	logic [IDX_W-1:0]   cur_q, root_q, pa_q, rd_q;
	logic [CLR_W-1:0]   i_q;
	logic [NODE_W-1:0]  node_count_q;
	logic [COUNT_W-1:0] count_q;
	logic               sel_b_q, acc_q;
	logic               out_valid_q, out_acc_q;
	logic [COUNT_W-1:0] out_total_q;

	logic [PROD_W-1:0] prod_a, prod_b;
	logic [REM_W-1:0]  rem_a, rem_b;
	logic [IDX_W-1:0]  find_start;
	logic              fire, acc_now, mem_we, mem_re;
	logic [IDX_W-1:0]  waddr, wdata, raddr;

	assign fire = in_valid && ctl.take;

	assign prod_a = PROD_W'(a_q) * PROD_W'(RECIP);
	assign prod_b = PROD_W'(b_q) * PROD_W'(RECIP);
	assign rem_a = REM_W'(a_q) - REM_W'(qa_q) * REM_W'(MAX_NODES);
	assign rem_b = REM_W'(b_q) - REM_W'(qb_q) * REM_W'(MAX_NODES);

	assign find_start = sel_b_q ? b_idx_q : a_idx_q;
	assign acc_now = (op_t'(op_q) == OP_OFFER) && (pa_q != root_q);

	assign status.fire        = fire;
	assign status.op_clr      = op_t'(op_q) == OP_CLEAR;
	assign status.op_none     = !(op_t'(op_q) == OP_LINK || op_t'(op_q) == OP_OFFER);
	assign status.rd_ne_root  = rd_q != root_q;
	assign status.cur_eq_root = cur_q == root_q;
	assign status.sel_b       = sel_b_q;
	assign status.clr_done    = (i_q > CLR_W'(node_count_q)) || (32'(i_q) >= MAX_NODES);
	assign status.out_busy    = out_valid_q && !out_ready;

	always_comb begin
		mem_we = 1'b1;
		waddr = cur_q;
		wdata = root_q;
		case (ctl.wr_sel)
			WR_CUR: begin
				waddr = cur_q;
				wdata = root_q;
			end
			WR_PA: begin
				waddr = pa_q;
				wdata = root_q;
			end
			WR_CLR: begin
				waddr = IDX_W'(i_q);
				wdata = IDX_W'(i_q);
			end
			default: mem_we = 1'b0;
		endcase
		mem_re = 1'b1;
		case (ctl.rd_sel)
			RD_ROOT: raddr = root_q;
			RD_CUR:  raddr = cur_q;
			default: begin
				raddr = cur_q;
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			op_q <= in_opcode;
			a_q <= in_node_a;
			b_q <= in_node_b;
		end
		if (ctl.ld_quot) begin
			qa_q <= prod_a[SHIFT +: NODE_W];
			qb_q <= prod_b[SHIFT +: NODE_W];
		end
		if (ctl.ld_idx) begin
			a_idx_q <= IDX_W'(rem_a[NODE_W-1:0]);
			b_idx_q <= IDX_W'(rem_b[NODE_W-1:0]);
		end
		if (ctl.ld_find) begin
			cur_q <= find_start;
			root_q <= find_start;
		end else if (ctl.ld_cur_rd) begin
			cur_q <= rd_q;
		end else if (ctl.ld_root_rd) begin
			root_q <= rd_q;
		end
		if (ctl.ld_pa) begin
			pa_q <= root_q;
		end
		if (ctl.clr_init) begin
			i_q <= CLR_W'(1);
		end else if (ctl.clr_inc) begin
			i_q <= i_q + 1'b1;
		end
		if (ctl.ld_out) begin
			out_acc_q <= acc_q;
			out_total_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			count_q <= '0;
			sel_b_q <= 1'b0;
			acc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_node_count;
			end
			if (fire) begin
				sel_b_q <= 1'b0;
				acc_q <= 1'b0;
			end else if (ctl.ld_pa) begin
				sel_b_q <= 1'b1;
			end else if (ctl.ld_union) begin
				acc_q <= acc_now;
			end
			if (ctl.clr_init) begin
				count_q <= '0;
			end else if (ctl.ld_union && acc_now && count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_accepted = out_acc_q;
	assign out_total = out_total_q;

endmodule

/* sv/union_find_edge_filter_unit.sv */
// Top level of the union-find edge filter.
// Depends on ufef_pkg, the channel interfaces, ufef_sequencer and ufef_datapath.
//
// The block keeps a parent table of MAX_NODES entries and answers one
// result word for every item word. An item carries an opcode and two node
// numbers: clear makes nodes 1 to node_count their own sets and zeroes the
// count, link joins two sets, offer joins them only when they differ and
// then reports the edge as accepted. The cfg channel writes node_count; the
// user is to do so only while the block is idle, which the block itself
// does not enforce. The cfg channel is always ready. One item is processed
// at a time by a microcoded sequencer that uses the parent table's read and
// write ports in separate steps, which sets the pace. An offer or link walks
// from each node to its root, compresses the path, and links the two roots;
// a clear writes each entry in turn. The result sits in an output register;
// the next item is taken while it waits, and the block stalls before it
// loads the result only if that register is still full. Reset empties the
// result register, zeroes the count and sets node_count to 1023; the parent
// table is undefined until the first clear.
module union_find_edge_filter_unit import ufef_pkg::*; #(
	parameter int unsigned MAX_NODES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	ufef_in_if.sink    item,
	ufef_out_if.source result,
	ufef_cfg_if.sink   cfg
);

	ctl_t    ctl;
	status_t status;

	ufef_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	ufef_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.status         (status),
		.in_valid       (item.valid),
		.in_opcode      (item.opcode),
		.in_node_a      (item.node_a),
		.in_node_b      (item.node_b),
		.cfg_valid      (cfg.valid),
		.cfg_node_count (cfg.node_count),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_accepted   (result.accepted),
		.out_total      (result.accepted_total)
	);

	assign item.ready = ctl.take;
	assign cfg.ready = 1'b1;

endmodule

/* sv/ufef_checker.sv */
// Port checker for the union-find edge filter, bound to the top level.
// Depends on ufef_pkg for field widths.
module ufef_port_checker import ufef_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_accepted,
	input logic [COUNT_W-1:0] out_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result word dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_accepted) && $stable(out_total))
		else $error("Result word changed while stalled.");

	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_accepted |-> out_total != '0)
		else $error("Accepted edge reported with a zero total.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second item word taken while one is in progress.");

endmodule

bind union_find_edge_filter_unit ufef_port_checker u_ufef_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_accepted (result.accepted),
	.out_total    (result.accepted_total)
);
